[rtl/core/bajd_pkg.sv]
// ----------------------------------------------------------------------------
// bajd_pkg
// shared types and constants of the block ack request jump detector
// ----------------------------------------------------------------------------
package bajd_pkg;

	localparam logic [15:0] MIN_LENGTH    = 16'd20;
	localparam int          MULTI_TID_BIT = 1;
	localparam logic [11:0] THRESH_RESET  = 12'd512;
	localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
	localparam logic [1:0]  REG_THRESHOLD = 2'd0;

	typedef enum logic [2:0] {
		ST_SHORT      = 3'd0,
		ST_MULTI_TID  = 3'd1,
		ST_GROUP      = 3'd2,
		ST_BASELINE   = 3'd3,
		ST_NORMAL     = 3'd4,
		ST_SUSPICIOUS = 3'd5
	} status_t;

	// one table entry as stored in the entry memory
	typedef struct packed {
		logic [47:0] receiver;
		logic [47:0] transmitter;
		logic [3:0]  tid;
		logic [11:0] last_seq;
		logic [31:0] last_time;
		logic [31:0] total;
		logic [31:0] suspicious;
		logic [11:0] susp_jump;
	} entry_t;

endpackage

[rtl/core/bajd_table.sv]
// ----------------------------------------------------------------------------
// bajd_table
// entry memory: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module bajd_table
	import bajd_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/core/block_ack_request_jump_detector.sv]
// ----------------------------------------------------------------------------
// block_ack_request_jump_detector
// block ack request filter, table lookup and sequence jump tracking
// ----------------------------------------------------------------------------
// a dropped request is answered from the idle state; a lookup scans at most the used
// entries (used = entries allocated, TABLE_ENTRIES when the table is full), then runs
// the decide, read and update steps; one request at a time, set by the entry memory
// scan at one entry per cycle through a single read port
// reset clears control state and the fill count; the table needs no clearing
// the result strobe lasts one cycle and the receiver cannot stall
module block_ack_request_jump_detector
	import bajd_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] frame_length,
	input  logic [47:0] receiver_addr,
	input  logic [47:0] transmitter_addr,
	input  logic [15:0] bar_control,
	input  logic [15:0] start_seq_control,
	input  logic [31:0] timestamp,
	output logic        done,
	output logic [2:0]  status,
	output logic [4:0]  entry_index,
	output logic        new_entry,
	output logic [11:0] jump_distance,
	output logic [31:0] request_count,
	output logic [31:0] suspicious_count
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_READ, S_UPDATE
	} state_t;

	state_t        state_q;
	logic [11:0]   thresh_q;
	logic [CW-1:0] used_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] cmp_idx_q;
	logic          cmp_vld_q;
	logic          found_q;
	logic [AW-1:0] hit_idx_q;
	logic [AW-1:0] old_idx_q;
	logic [31:0]   old_time_q;
	logic          old_vld_q;
	logic [AW-1:0] idx_q;
	logic          fresh_q;
	logic [47:0]   ra_q;
	logic [47:0]   ta_q;
	logic [3:0]    tid_q;
	logic [11:0]   ssn_q;
	logic [31:0]   now_q;

	entry_t        rd_data;
	entry_t        wr_data;
	logic          wr_en;
	logic [AW-1:0] mem_rd_addr;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_THRESHOLD) ? {20'd0, thresh_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && paddr == REG_THRESHOLD) begin
			thresh_q <= pwdata[11:0];
		end
	end

	bajd_table #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_q),
		.wr_data (wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	// entry 0 is read at the accepting edge, the chosen entry ahead of the update
	assign mem_rd_addr = (state_q == S_DECIDE || state_q == S_READ) ? idx_q :
		((state_q == S_IDLE) ? '0 : rd_addr_q);
	assign busy = (state_q != S_IDLE);

	// read-modify-write of the chosen entry
	logic [11:0] seq_gap;
	logic        susp;
	logic [31:0] tot_base;
	logic [31:0] sus_base;
	always_comb begin
		seq_gap = ssn_q - rd_data.last_seq;
		susp = !fresh_q && (seq_gap > thresh_q);
		tot_base = fresh_q ? 32'd0 : rd_data.total;
		sus_base = fresh_q ? 32'd0 : rd_data.suspicious;
		wr_data.receiver    = ra_q;
		wr_data.transmitter = ta_q;
		wr_data.tid         = tid_q;
		wr_data.last_seq    = ssn_q;
		wr_data.last_time   = now_q;
		wr_data.total       = (tot_base == COUNT_MAX) ? tot_base : tot_base + 32'd1;
		wr_data.suspicious  = (susp && sus_base != COUNT_MAX) ? sus_base + 32'd1 : sus_base;
		wr_data.susp_jump   = fresh_q ? 12'd0 : (susp ? seq_gap : rd_data.susp_jump);
		wr_en = (state_q == S_UPDATE);
	end

	// compare of the entry read last cycle
	logic match;
	assign match = rd_data.tid == tid_q && rd_data.receiver == ra_q &&
		rd_data.transmitter == ta_q;

	// control sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done      <= 1'b0;
			rd_addr_q <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			old_vld_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ra_q  <= receiver_addr;
						ta_q  <= transmitter_addr;
						tid_q <= bar_control[15:12];
						ssn_q <= start_seq_control[15:4];
						now_q <= timestamp;
						status           <= ST_SHORT;
						entry_index      <= 5'd0;
						new_entry        <= 1'b0;
						jump_distance    <= 12'd0;
						request_count    <= 32'd0;
						suspicious_count <= 32'd0;
						found_q   <= 1'b0;
						old_vld_q <= 1'b0;
						rd_addr_q <= (LAST == '0) ? '0 : AW'(1);
						cmp_idx_q <= '0;
						cmp_vld_q <= 1'b0;
						if (frame_length < MIN_LENGTH) begin
							done <= 1'b1;
						end else if (bar_control[MULTI_TID_BIT]) begin
							status <= ST_MULTI_TID;
							done   <= 1'b1;
						end else if (receiver_addr[0] || transmitter_addr[0]) begin
							status <= ST_GROUP;
							done   <= 1'b1;
						end else if (used_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q   <= S_SCAN;
							cmp_vld_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					// one entry compared per cycle, the read runs one entry ahead
					if (cmp_vld_q) begin
						if (match) begin
							found_q   <= 1'b1;
							hit_idx_q <= cmp_idx_q;
						end
						if (!old_vld_q || rd_data.last_time < old_time_q) begin
							old_vld_q  <= 1'b1;
							old_idx_q  <= cmp_idx_q;
							old_time_q <= rd_data.last_time;
						end
					end
					if (found_q || (cmp_vld_q && match) ||
						(CW'(cmp_idx_q) + CW'(1) >= used_q)) begin
						cmp_vld_q <= 1'b0;
						state_q   <= S_DECIDE;
					end else begin
						cmp_idx_q <= cmp_idx_q + AW'(1);
						rd_addr_q <= (rd_addr_q == LAST) ? rd_addr_q : rd_addr_q + AW'(1);
					end
				end
				S_DECIDE: begin
					// read of the chosen entry issued here and held through the read step
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					status           <= fresh_q ? ST_BASELINE :
						(susp ? ST_SUSPICIOUS : ST_NORMAL);
					entry_index      <= 5'(idx_q);
					new_entry        <= fresh_q;
					jump_distance    <= fresh_q ? 12'd0 : seq_gap;
					request_count    <= wr_data.total;
					suspicious_count <= wr_data.suspicious;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// entry choice, settled on entry to the decide step
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			idx_q   <= AW'(used_q);
			fresh_q <= 1'b1;
		end else if (state_q == S_SCAN &&
			(found_q || (cmp_vld_q && match) ||
			(CW'(cmp_idx_q) + CW'(1) >= used_q))) begin
			if (found_q) begin
				idx_q   <= hit_idx_q;
				fresh_q <= 1'b0;
			end else if (cmp_vld_q && match) begin
				idx_q   <= cmp_idx_q;
				fresh_q <= 1'b0;
			end else if (used_q != FULL) begin
				idx_q   <= AW'(used_q);
				fresh_q <= 1'b1;
			end else if (!old_vld_q || rd_data.last_time < old_time_q) begin
				idx_q   <= cmp_idx_q;
				fresh_q <= 1'b1;
			end else begin
				idx_q   <= old_idx_q;
				fresh_q <= 1'b1;
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (state_q == S_UPDATE && fresh_q && used_q != FULL &&
			CW'(idx_q) == used_q) begin
			used_q <= used_q + CW'(1);
		end
	end

endmodule
